// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared command and status codes of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned DataWidth   = 32;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit values in a ring memory
// ----------------------------------------------------------------------------
// A command is taken on every clock edge where start_i is high and busy_o is
// low; busy_o stays low, so one item can be issued each cycle.  Each item
// gives exactly one result, in the cycle after it is taken: done_o is high for
// a single cycle with data_o and status_o valid, and the receiver cannot
// stall it.  Pushes return data -1 and status ok, or status full when the
// ring already holds DEPTH values (the value is dropped).  Pops and peeks
// return the front or back value, or -1 with status empty.  Unused command
// codes return -1 with status ok and change nothing.  The values sit in one
// single-port synchronous memory of DEPTH words; the head index and entry
// count are flip-flops, so every address is known at the accept edge and the
// memory's registered read port lines up with the registered result.  A read
// always comes in a later cycle than the write of the entry, so no forwarding
// is needed.  There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [deq_pkg::CmdWidth-1:0]          cmd_i,
  input  logic signed [deq_pkg::DataWidth-1:0]  value_i,
  output logic                                  done_o,
  output logic signed [deq_pkg::DataWidth-1:0]  data_o,
  output logic [deq_pkg::StatusWidth-1:0]       status_o
);

  // index and count widths
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DepthW = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // ring state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // ring memory and its registered read port
  logic [deq_pkg::DataWidth-1:0] mem_q [DEPTH];
  logic [deq_pkg::DataWidth-1:0] rd_data_q;
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_addr;

  // result registers
  logic                    done_q;
  deq_pkg::status_e        status_q, status_d;
  logic                    rd_sel_q, rd_sel_d;

  logic          accept;
  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc, back_slot, tail_slot;
  logic [AW:0]   back_sum, tail_sum;

  // reduce a slot number below twice the depth into the ring range
  function automatic logic [AW-1:0] slot_wrap(input logic [AW:0] a);
    logic [AW:0] r;
    r = (a >= DepthW) ? a - DepthW : a;
    return r[AW-1:0];
  endfunction

  // busy_o is tied low, so the queue never holds off a command
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  // neighbors of the head, the free slot past the back and the back entry
  assign head_dec  = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign head_inc  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign back_sum  = {1'b0, head_q} + (AW+1)'(count_q);
  assign tail_sum  = back_sum - 1'b1;
  assign back_slot = slot_wrap(back_sum);
  assign tail_slot = slot_wrap(tail_sum);

  // command decode: memory access, state update and result status
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = head_q;
    status_d = deq_pkg::ST_OK;
    rd_sel_d = 1'b0;
    if (accept) begin
      case (deq_pkg::cmd_e'(cmd_i))
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            head_d   = head_dec;
            mem_addr = head_dec;
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            mem_addr = back_slot;
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            mem_addr = head_q;
            mem_re   = 1'b1;
            rd_sel_d = 1'b1;
            if (cmd_i == deq_pkg::CMD_POP_FRONT) begin
              head_d  = head_inc;
              count_d = count_q - 1'b1;
            end
          end
        end
        deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            mem_addr = tail_slot;
            mem_re   = 1'b1;
            rd_sel_d = 1'b1;
            if (cmd_i == deq_pkg::CMD_POP_BACK) begin
              count_d = count_q - 1'b1;
            end
          end
        end
        default: begin
          // unused codes: no state change, ok status
          status_d = deq_pkg::ST_OK;
        end
      endcase
    end
  end

  // single-port ring memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= value_i;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = rd_sel_q ? signed'(rd_data_q) : '1;

`ifndef SYNTHESIS
  // entry count never exceeds the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  // head index stays inside the ring
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastIdx)
    else $error("head index out of range");

  // every accepted item gives exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result strobe");

  // full is reported only when the ring held depth entries
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == deq_pkg::ST_FULL) |-> ($past(count_q) == DepthC))
    else $error("full reported on a ring with room");

  // ring state holds when no item is accepted
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q) && $stable(head_q))
    else $error("ring state changed without an item");
`endif

endmodule
